// ----- rtl/egcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

	localparam int OPW  = 31;
	localparam int CW   = 32;
	localparam int CNTW = $clog2(OPW);
	localparam int IN_TDATA_W  = ((2 * OPW + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OPW + 2 * CW + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_MUL_X,
		ST_SUB_X,
		ST_SUB_Y,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic           start;
		logic [OPW-1:0] dividend;
		logic [OPW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic           done;
		logic [OPW-1:0] quotient;
		logic [OPW-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/egcd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module egcd_div (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire egcd_pkg::div_req_t req,
	output egcd_pkg::div_rsp_t      rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [egcd_pkg::CNTW-1:0]   cnt_q;
	logic [egcd_pkg::OPW-1:0]    quo_q;
	logic [egcd_pkg::OPW-1:0]    rem_q;
	logic [egcd_pkg::OPW-1:0]    dvs_q;
	logic [egcd_pkg::OPW:0]      trial;
	logic [egcd_pkg::OPW:0]      diff;
	logic                        fits;

	// one quotient bit per cycle, restoring form
	assign trial = {rem_q, quo_q[egcd_pkg::OPW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= egcd_pkg::CNTW'(egcd_pkg::OPW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - egcd_pkg::CNTW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[egcd_pkg::OPW-2:0], fits};
			rem_q <= fits ? diff[egcd_pkg::OPW-1:0] : trial[egcd_pkg::OPW-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// ----- rtl/extended_gcd_bezout.sv -----
`timescale 1ns / 1ps
`default_nettype none

// extended euclid: takes one operand pair (a, b) and returns gcd and bezout
// coefficients x, y with a*x + b*y = gcd
// input channel s_*: one beat per pair, s_tready is high only while idle
// output channel m_*: one beat per pair, held in an output register
// each euclid step starts the shared 1-bit-per-cycle divider in its check
// cycle, waits in the div state for the quotient, then uses one shared
// multiplier over the mul_x, sub_x and sub_y states for the x and y updates
// a pair takes at most about 46 steps for 31-bit operands; b = 0 skips the
// divider and goes straight from the check to the finish state
// a new pair is not taken while one is in work: the next pair is taken in the
// idle cycle after the result is loaded into the output register
// reset clears the sequencer and the output valid, the block comes up idle
// if the receiver stalls, a finished result waits until the previous beat
// has been taken; the input stays blocked meanwhile
module extended_gcd_bezout (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    s_tvalid,
	output logic                                   s_tready,
	// a_value, b_value, zero pad
	input  wire  [egcd_pkg::IN_TDATA_W-1:0]        s_tdata,
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	// gcd_value, coeff_a, coeff_b, zero pad
	output logic [egcd_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	localparam int OPW = egcd_pkg::OPW;
	localparam int CW  = egcd_pkg::CW;

	egcd_pkg::state_t   state_q;
	egcd_pkg::state_t   state_d;
	egcd_pkg::div_req_t div_req;
	egcd_pkg::div_rsp_t div_rsp;

	logic [OPW-1:0] ro_q;
	logic [OPW-1:0] rn_q;
	logic [CW-1:0]  xo_q;
	logic [CW-1:0]  xn_q;
	logic [CW-1:0]  yo_q;
	logic [CW-1:0]  yn_q;
	logic [CW-1:0]  prod_q;
	logic [CW-1:0]  mul_b;
	logic [CW-1:0]  mul_lo;
	logic           m_valid_q;
	logic [OPW-1:0] out_gcd_q;
	logic [CW-1:0]  out_x_q;
	logic [CW-1:0]  out_y_q;
	logic           accept;
	logic           out_load;

	egcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// low bits of q * coef are all the wrapped result needs
	assign mul_b  = (state_q == egcd_pkg::ST_MUL_X) ? xn_q : yn_q;
	assign mul_lo = {1'b0, div_rsp.quotient} * mul_b;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = ro_q;
		div_req.divisor  = rn_q;
		unique case (state_q)
			egcd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = egcd_pkg::ST_CHECK;
			end
			egcd_pkg::ST_CHECK: begin
				if (rn_q == '0) begin
					state_d = egcd_pkg::ST_FINISH;
				end else begin
					div_req.start = 1'b1;
					state_d       = egcd_pkg::ST_DIV;
				end
			end
			egcd_pkg::ST_DIV: begin
				if (div_rsp.done) state_d = egcd_pkg::ST_MUL_X;
			end
			egcd_pkg::ST_MUL_X: state_d = egcd_pkg::ST_SUB_X;
			egcd_pkg::ST_SUB_X: state_d = egcd_pkg::ST_SUB_Y;
			egcd_pkg::ST_SUB_Y: state_d = egcd_pkg::ST_CHECK;
			egcd_pkg::ST_FINISH: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = egcd_pkg::ST_IDLE;
				end
			end
			default: state_d = egcd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= egcd_pkg::ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ro_q <= s_tdata[OPW-1:0];
			rn_q <= s_tdata[2*OPW-1:OPW];
			xo_q <= CW'(1);
			xn_q <= '0;
			yo_q <= '0;
			yn_q <= CW'(1);
		end
		unique case (state_q)
			egcd_pkg::ST_MUL_X: prod_q <= mul_lo;
			egcd_pkg::ST_SUB_X: begin
				xo_q   <= xn_q;
				xn_q   <= xo_q - prod_q;
				prod_q <= mul_lo;
			end
			egcd_pkg::ST_SUB_Y: begin
				yo_q <= yn_q;
				yn_q <= yo_q - prod_q;
				ro_q <= rn_q;
				rn_q <= div_rsp.remainder;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_gcd_q <= ro_q;
			out_x_q   <= xo_q;
			out_y_q   <= yo_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(egcd_pkg::OUT_TDATA_W - OPW - 2 * CW){1'b0}},
		out_y_q, out_x_q, out_gcd_q};

endmodule

`default_nettype wire
